// ----- hw/rtl/quaternion_point_transform_filter_assert.svh -----
// Assertion shorthands for the checker file of the point transform filter.
// Every property is clocked on clk_i and ignored while rst_ni is low.
`ifndef QUATERNION_POINT_TRANSFORM_FILTER_ASSERT_SVH
`define QUATERNION_POINT_TRANSFORM_FILTER_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define QPTF_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define QPTF_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/qptf_pkg.sv -----
`default_nettype none

package qptf_pkg;

  // Coordinate, offset and height width, signed Q16.16.
  localparam int COORD_WIDTH = 32;
  localparam int ROT_W       = 32;
  localparam int Q_W         = 16;
  localparam int CFG_DATA_W  = (COORD_WIDTH > ROT_W) ? COORD_WIDTH : ROT_W;
  localparam int CFG_IDX_W   = 3;

  // Matrix entries are Q.28 and reach about +/-2^32 for non-unit quaternions.
  localparam int FRAC_SHIFT  = 28;
  localparam int ENTRY_W     = 2 * Q_W + 2;

  localparam logic signed [ENTRY_W-1:0] MAT_ONE = ENTRY_W'(1) << FRAC_SHIFT;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;

  localparam logic [ROT_W-1:0] ROT_XY_RESET       = '0;
  localparam logic [ROT_W-1:0] ROT_ZW_RESET       = ROT_W'(32'h4000_0000);
  localparam coord_t           HEIGHT_UPPER_RESET = coord_t'(131072);
  localparam coord_t           HEIGHT_LOWER_RESET = coord_t'(-32768);

  typedef enum logic [CFG_IDX_W-1:0] {
    RegRotXy       = 3'd0,
    RegRotZw       = 3'd1,
    RegOffsetX     = 3'd2,
    RegOffsetY     = 3'd3,
    RegOffsetZ     = 3'd4,
    RegHeightUpper = 3'd5,
    RegHeightLower = 3'd6
  } reg_idx_e;

  typedef struct packed {
    coord_t point_x;
    coord_t point_y;
    coord_t point_z;
    logic   point_finite;
  } point_in_t;

  typedef struct packed {
    coord_t global_x;
    coord_t global_y;
    coord_t global_z;
  } point_out_t;

  // Settings handed from the register block to the datapath.
  typedef struct packed {
    logic [8:0][ENTRY_W-1:0]     matrix;
    logic [2:0][COORD_WIDTH-1:0] offset;
    coord_t                      height_upper;
    coord_t                      height_lower;
  } xform_cfg_t;

endpackage

`default_nettype wire

// ----- hw/rtl/qptf_cfg.sv -----
`default_nettype none

module qptf_cfg import qptf_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  output xform_cfg_t                 cfg_o
);

  logic [ROT_W-1:0]            rot_xy_q, rot_xy_d;
  logic [ROT_W-1:0]            rot_zw_q, rot_zw_d;
  logic [2:0][COORD_WIDTH-1:0] offset_q, offset_d;
  coord_t                      upper_q, upper_d;
  coord_t                      lower_q, lower_d;
  logic [8:0][ENTRY_W-1:0]     matrix_q, matrix_d;

  logic signed [ENTRY_W-1:0] qx, qy, qz, qw;
  logic signed [ENTRY_W-1:0] xx, yy, zz, xy, xz, yz, xw, yw, zw;

  always_comb begin
    rot_xy_d = rot_xy_q;
    rot_zw_d = rot_zw_q;
    offset_d = offset_q;
    upper_d  = upper_q;
    lower_d  = lower_q;
    if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        RegRotXy:       rot_xy_d    = cfg_data_i[ROT_W-1:0];
        RegRotZw:       rot_zw_d    = cfg_data_i[ROT_W-1:0];
        RegOffsetX:     offset_d[0] = cfg_data_i[COORD_WIDTH-1:0];
        RegOffsetY:     offset_d[1] = cfg_data_i[COORD_WIDTH-1:0];
        RegOffsetZ:     offset_d[2] = cfg_data_i[COORD_WIDTH-1:0];
        RegHeightUpper: upper_d     = coord_t'(cfg_data_i[COORD_WIDTH-1:0]);
        RegHeightLower: lower_d     = coord_t'(cfg_data_i[COORD_WIDTH-1:0]);
        default: ;
      endcase
    end
  end

  // The matrix follows the quaternion in the same cycle as the write, so it
  // is valid as soon as the rotation registers are.
  always_comb begin
    qx = ENTRY_W'($signed(rot_xy_d[Q_W-1:0]));
    qy = ENTRY_W'($signed(rot_xy_d[2*Q_W-1:Q_W]));
    qz = ENTRY_W'($signed(rot_zw_d[Q_W-1:0]));
    qw = ENTRY_W'($signed(rot_zw_d[2*Q_W-1:Q_W]));
    xx = qx * qx;
    yy = qy * qy;
    zz = qz * qz;
    xy = qx * qy;
    xz = qx * qz;
    yz = qy * qz;
    xw = qx * qw;
    yw = qy * qw;
    zw = qz * qw;
    matrix_d[0] = MAT_ONE - ((yy + zz) <<< 1);
    matrix_d[1] = (xy - zw) <<< 1;
    matrix_d[2] = (xz + yw) <<< 1;
    matrix_d[3] = (xy + zw) <<< 1;
    matrix_d[4] = MAT_ONE - ((xx + zz) <<< 1);
    matrix_d[5] = (yz - xw) <<< 1;
    matrix_d[6] = (xz - yw) <<< 1;
    matrix_d[7] = (yz + xw) <<< 1;
    matrix_d[8] = MAT_ONE - ((xx + yy) <<< 1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rot_xy_q <= ROT_XY_RESET;
      rot_zw_q <= ROT_ZW_RESET;
      offset_q <= '0;
      upper_q  <= HEIGHT_UPPER_RESET;
      lower_q  <= HEIGHT_LOWER_RESET;
      matrix_q <= {MAT_ONE, {3{ENTRY_W'(0)}}, MAT_ONE, {3{ENTRY_W'(0)}}, MAT_ONE};
    end else begin
      rot_xy_q <= rot_xy_d;
      rot_zw_q <= rot_zw_d;
      offset_q <= offset_d;
      upper_q  <= upper_d;
      lower_q  <= lower_d;
      matrix_q <= matrix_d;
    end
  end

  assign cfg_o = {matrix_q, offset_q, upper_q, lower_q};

endmodule

`default_nettype wire

// ----- hw/rtl/quaternion_point_transform_filter.sv -----
`default_nettype none

// Rigid transform point filter. Each request carries one sensor-frame point in
// signed Q16.16; it is rotated by the 3x3 matrix built from the configured Q1.14
// quaternion (used as written, not renormalized), rounded half up to Q16.16 and
// shifted by the configured offset, with each output saturated. Points flagged
// as not finite, and points whose rotated z before the offset lies outside
// [height_lower, height_upper], produce no result. The block takes one request
// per clock cycle while in_ready_o is high; the edge that accepts a point loads
// the input register, and a kept point then passes through the partial-product,
// sum and result registers, in that order, before it appears on the output. The
// multiplier array forms all nine point-by-entry products. A write to a rotation
// register rebuilds the matrix at the same clock edge.
module quaternion_point_transform_filter import qptf_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire point_in_t             in_point_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output point_out_t                 out_point_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  // Each entry is split into an unsigned low part and a signed high part so
  // that no single multiplier grows with the full entry width.
  localparam int LO_W  = (ENTRY_W + 1) / 2;
  localparam int HI_W  = ENTRY_W - LO_W;
  localparam int PL_W  = COORD_WIDTH + LO_W + 1;
  localparam int PH_W  = COORD_WIDTH + HI_W;
  localparam int ACC_W = COORD_WIDTH + ENTRY_W + 2;
  localparam int GW    = ACC_W - FRAC_SHIFT;
  localparam int SUM_W = GW + 1;

  localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (FRAC_SHIFT - 1);
  localparam logic signed [SUM_W-1:0] SAT_MAX =
    SUM_W'({1'b0, {(COORD_WIDTH-1){1'b1}}});
  localparam logic signed [SUM_W-1:0] SAT_MIN = ~SAT_MAX;

  xform_cfg_t cfg;

  qptf_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  logic rdy1, rdy2, rdy3, rdy_out;

  logic              s1_v_q, s1_v_d;
  logic              s2_v_q, s2_v_d;
  logic              s3_v_q, s3_v_d;
  logic              out_v_q, out_v_d;

  coord_t                  s1_pt_q [3];
  coord_t                  s1_pt_d [3];
  logic signed [PL_W-1:0]  plo_q [9];
  logic signed [PL_W-1:0]  plo_d [9];
  logic signed [PH_W-1:0]  phi_q [9];
  logic signed [PH_W-1:0]  phi_d [9];
  logic signed [ACC_W-1:0] lsum [3];
  logic signed [ACC_W-1:0] hsum [3];
  logic signed [ACC_W-1:0] acc [3];
  logic signed [GW-1:0]    g_q [3];
  logic signed [GW-1:0]    g_d [3];
  logic signed [GW-1:0]    upper_g, lower_g;
  logic signed [SUM_W-1:0] tsum [3];
  coord_t                  sat [3];
  logic                    keep;
  point_out_t              out_q, out_d;

  // A stage moves on when it is empty or when the stage after it moves on.
  assign rdy_out    = !out_v_q || out_ready_i;
  assign rdy3       = !s3_v_q || rdy_out;
  assign rdy2       = !s2_v_q || rdy3;
  assign rdy1       = !s1_v_q || rdy2;
  assign in_ready_o = rdy1;

  // Points that are not finite never enter the pipeline.
  assign s1_v_d     = in_valid_i && in_point_i.point_finite;
  assign s2_v_d     = s1_v_q;
  assign s3_v_d     = s2_v_q;
  assign out_v_d    = s3_v_q && keep;

  assign s1_pt_d[0] = $signed(in_point_i.point_x);
  assign s1_pt_d[1] = $signed(in_point_i.point_y);
  assign s1_pt_d[2] = $signed(in_point_i.point_z);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        plo_d[3*i+j] = PL_W'(s1_pt_q[j]) *
                       PL_W'($signed({1'b0, cfg.matrix[3*i+j][LO_W-1:0]}));
        phi_d[3*i+j] = PH_W'(s1_pt_q[j]) *
                       PH_W'($signed(cfg.matrix[3*i+j][ENTRY_W-1:LO_W]));
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      lsum[i] = ACC_W'(plo_q[3*i]) + ACC_W'(plo_q[3*i+1]) + ACC_W'(plo_q[3*i+2]);
      hsum[i] = ACC_W'(phi_q[3*i]) + ACC_W'(phi_q[3*i+1]) + ACC_W'(phi_q[3*i+2]);
      acc[i]  = (hsum[i] <<< LO_W) + lsum[i] + ROUND_HALF;
      g_d[i]  = acc[i][ACC_W-1:FRAC_SHIFT];
    end
  end

  // Height test on rotated z before the offset; equal to a bound is kept.
  always_comb begin
    upper_g = GW'($signed(cfg.height_upper));
    lower_g = GW'($signed(cfg.height_lower));
    keep    = !(g_q[2] > upper_g) && !(g_q[2] < lower_g);
    for (int i = 0; i < 3; i++) begin
      tsum[i] = SUM_W'(g_q[i]) + SUM_W'($signed(cfg.offset[i]));
      if (tsum[i] > SAT_MAX) begin
        sat[i] = SAT_MAX[COORD_WIDTH-1:0];
      end else if (tsum[i] < SAT_MIN) begin
        sat[i] = SAT_MIN[COORD_WIDTH-1:0];
      end else begin
        sat[i] = tsum[i][COORD_WIDTH-1:0];
      end
    end
    out_d.global_x = sat[0];
    out_d.global_y = sat[1];
    out_d.global_z = sat[2];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (rdy1) begin
        s1_v_q <= s1_v_d;
      end
      if (rdy2) begin
        s2_v_q <= s2_v_d;
      end
      if (rdy3) begin
        s3_v_q <= s3_v_d;
      end
      if (rdy_out) begin
        out_v_q <= out_v_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && s1_v_d) begin
      s1_pt_q <= s1_pt_d;
    end
    if (rdy2 && s1_v_q) begin
      plo_q <= plo_d;
      phi_q <= phi_d;
    end
    if (rdy3 && s2_v_q) begin
      g_q <= g_d;
    end
    if (rdy_out && out_v_d) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_point_o = out_q;

endmodule

`default_nettype wire

// ----- hw/rtl/qptf_checker.sv -----
`default_nettype none

`include "quaternion_point_transform_filter_assert.svh"

module qptf_checker import qptf_pkg::*; (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_ready_o,
  input wire point_in_t  in_point_i,
  input wire logic       out_valid_o,
  input wire logic       out_ready_i,
  input wire point_out_t out_point_o
);

  // With the output free to move, nothing inside may hold off a new request.
  `QPTF_ASSERT_IMP(a_ready_when_drained, out_ready_i || !out_valid_o, in_ready_o, "input stalled while output could drain")

  // A result on offer always carries a fully defined point.
  `QPTF_ASSERT_IMP(a_out_known, out_valid_o, !$isunknown(out_point_o), "result offered with undefined bits")

  `QPTF_ASSERT_NXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_point_o), "stalled result changed or vanished")

endmodule

bind quaternion_point_transform_filter qptf_checker u_qptf_checker (.*);

`default_nettype wire
